>>> rtl/adaptive_beacon_period_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive beacon period block
// Clocked, reset-qualified property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_BEACON_PERIOD_ASSERT_SVH
`define ADAPTIVE_BEACON_PERIOD_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent
`define ABP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("abp assertion failed");

// Check a consequent in the cycle after its antecedent
`define ABP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("abp assertion failed");

`endif

>>> rtl/abp_pkg.sv
// ----------------------------------------------------------------------------
// abp_pkg
// Shared constants, codes and types of the adaptive beacon period block.
// ----------------------------------------------------------------------------
package abp_pkg;

  // Fixed-point format and identity size
  localparam int FRAC_BITS = 8;
  localparam int ID_BYTES  = 8;
  localparam logic [15:0] FP_ONE = 16'(1 << FRAC_BITS);

  // Port widths
  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 120;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Commands carried on in_tuser
  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_HEARD     = 3'd1,
    CMD_SEND_DONE = 3'd2,
    CMD_SET_ID    = 3'd3,
    CMD_CLEAR_ID  = 3'd4,
    CMD_START     = 3'd5
  } cmd_t;

  // Result kinds carried on out_tuser
  typedef enum logic [1:0] {
    KIND_DONE   = 2'd0,
    KIND_BCAST  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GROW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FSTEP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIM   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIM    = 3'd6;

  // Reset values
  localparam logic [15:0] RST_MIN_PERIOD = 16'd2560;
  localparam logic [15:0] RST_MAX_PERIOD = 16'd15360;
  localparam logic [7:0]  RST_DECAY      = 8'd248;
  localparam logic [9:0]  RST_GROW       = 10'd320;
  localparam logic [7:0]  RST_FSTEP      = 8'd3;
  localparam logic [15:0] RST_HIGH_LIM   = 16'd256;
  localparam logic [15:0] RST_LOW_LIM    = 16'd128;
  localparam logic [15:0] RST_RATE       = 16'd800;
  localparam logic [15:0] RST_PERIOD     = 16'd2560;

endpackage

>>> rtl/adaptive_beacon_period.sv
// ----------------------------------------------------------------------------
// adaptive_beacon_period
// Identity beacon scheduler with an adaptive 8.8 fixed-point period.
//
//   channel | direction | ports                      | contents
//   in      | slave     | in_tvalid/tready/tdata/tuser  | one command item
//   out     | master    | out_tvalid/tready/tdata/tuser | one result per item
//   cfg     | slave     | cfg_valid/ready/index/data | register writes
//
// Most commands finish at once; a tick that does not reach the period only
// decays the rate, one that reaches it also adapts and keeps or grows it, a
// shrink adds one pass of the radix-2 divider, and start runs two passes.
// The multiplier is shared across sequencer states and the divider by shrink
// and start, both stepped by the sequencer. in_tready is high only while the sequencer is
// idle; a full output register stalls the sequencer before it returns to idle,
// and a finished result waits there while the next item is taken.
// Reset is synchronous.
// ----------------------------------------------------------------------------
module adaptive_beacon_period (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: identity_bytes[63:0], id_len[67:64], link_accepts[68]
  input  logic [abp_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: command[2:0]
  input  logic [abp_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata: sequence_number[15:0], period_now[31:16], rate_estimate[47:32],
  //            identity_out[111:48], identity_count[115:112], send_taken[116]
  output logic [abp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // out_tuser: result_kind[1:0]
  output logic [abp_pkg::OUT_TUSER_W-1:0]   out_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [abp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [abp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import abp_pkg::*;

  localparam int DIVW = 16 + FRAC_BITS;
  localparam int CNTW = $clog2(DIVW + 1);
  localparam int CMPW = 16 + FRAC_BITS;
  localparam int PADW = OUT_TDATA_W - 117;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK_DECAY,
    S_TICK_CHECK,
    S_ADAPT_RATE,
    S_ADAPT_SEL,
    S_GROW,
    S_SHRINK,
    S_SHRINK_FIN,
    S_CLAMP,
    S_START_DIV2,
    S_START_FIN,
    S_DIV,
    S_DONE
  } state_t;

  // Configuration registers
  logic [15:0] min_r, max_r, high_r, low_r;
  logic [7:0]  decay_r, fstep_r;
  logic [9:0]  grow_r;

  // Block state
  state_t      state_r, div_ret_r;
  logic [63:0] id_r;
  logic [3:0]  id_len_r;
  logic [7:0]  sc_r, heard_r;
  logic [15:0] rate_r, period_r, next_seq_r;
  logic        pending_r;

  // Working registers
  logic [15:0] work_r, adapt_rate_r;
  logic        accepts_r;
  logic [DIVW-1:0] quo_r;
  logic [15:0] rem_r, den_r;
  logic [CNTW-1:0] cnt_r;

  // Result under construction
  kind_t       res_kind_r;
  logic [15:0] res_seq_r;
  logic [63:0] res_id_r;
  logic [3:0]  res_cnt_r;
  logic        res_taken_r;

  // Output register
  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [15:0] out_seq_r, out_period_r, out_rate_r;
  logic [63:0] out_id_r;
  logic [3:0]  out_cnt_r;
  logic        out_taken_r;

  // Input field views
  cmd_t        cmd;
  logic [63:0] in_id;
  logic [3:0]  in_len;
  logic        in_accepts;
  logic [63:0] id_masked;
  logic        in_fire;
  logic        len_bad;

  assign cmd        = cmd_t'(in_tuser);
  assign in_id      = in_tdata[63:0];
  assign in_len     = in_tdata[67:64];
  assign in_accepts = in_tdata[68];
  assign in_fire    = in_tvalid && in_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign len_bad    = (in_len == 4'd0) || (in_len > 4'(ID_BYTES));

  // Keep only the bytes below the given length
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      id_masked[8*i +: 8] = (4'(i) < in_len) ? in_id[8*i +: 8] : 8'd0;
    end
  end

  // One minus the decay fraction, floored at zero
  logic [15:0] decay_comp;
  assign decay_comp = (16'(decay_r) < FP_ONE) ? (FP_ONE - 16'(decay_r)) : 16'd0;

  // Shared multiplier with truncating shift and saturation
  logic [15:0] mul_a, mul_b, mul_sat;
  logic [31:0] mul_p, mul_sh;

  always_comb begin
    unique case (state_r)
      S_TICK_DECAY: begin
        mul_a = rate_r;
        mul_b = 16'(decay_r);
      end
      S_ADAPT_RATE: begin
        mul_a = rate_r;
        mul_b = decay_comp;
      end
      S_GROW: begin
        mul_a = work_r;
        mul_b = 16'(grow_r);
      end
      S_SHRINK: begin
        mul_a = 16'(fstep_r);
        mul_b = work_r;
      end
      default: begin
        mul_a = 16'd0;
        mul_b = 16'd0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign mul_sh  = mul_p >> FRAC_BITS;
  assign mul_sat = (|mul_sh[31:16]) ? 16'hFFFF : mul_sh[15:0];

  // Decayed rate plus messages heard this second, saturated
  logic [CMPW:0] rsum;
  logic [15:0]   rsum_sat;
  assign rsum     = (CMPW+1)'(mul_sat) + (CMPW+1)'({heard_r, {FRAC_BITS{1'b0}}});
  assign rsum_sat = (|rsum[CMPW:16]) ? 16'hFFFF : rsum[15:0];

  // Shrink divisor: one plus step times period, saturated
  logic [16:0] sdiv_sum;
  logic [15:0] sdiv;
  assign sdiv_sum = 17'(FP_ONE) + 17'(mul_sat);
  assign sdiv     = sdiv_sum[16] ? 16'hFFFF : sdiv_sum[15:0];

  // Divider step: one quotient bit a cycle; a zero divisor gives all ones
  logic [16:0] trial, diff;
  logic        trial_ge;
  logic [15:0] div_q_sat;
  assign trial     = {rem_r, quo_r[DIVW-1]};
  assign diff      = trial - {1'b0, den_r};
  assign trial_ge  = (trial >= {1'b0, den_r});
  assign div_q_sat = (|quo_r[DIVW-1:16]) ? 16'hFFFF : quo_r[15:0];

  // Seconds count against the period
  logic [CMPW-1:0] sc_fp;
  logic            period_not_due;
  assign sc_fp          = CMPW'({sc_r, {FRAC_BITS{1'b0}}});
  assign period_not_due = sc_fp < CMPW'(period_r);

  // Clamp the candidate period, lower bound first
  logic [15:0] clamped;
  always_comb begin
    priority if (work_r < min_r) begin
      clamped = min_r;
    end else if (work_r > max_r) begin
      clamped = max_r;
    end else begin
      clamped = work_r;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r   <= RST_MIN_PERIOD;
      max_r   <= RST_MAX_PERIOD;
      decay_r <= RST_DECAY;
      grow_r  <= RST_GROW;
      fstep_r <= RST_FSTEP;
      high_r  <= RST_HIGH_LIM;
      low_r   <= RST_LOW_LIM;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_PERIOD: min_r   <= cfg_data;
        CFG_MAX_PERIOD: max_r   <= cfg_data;
        CFG_DECAY:      decay_r <= cfg_data[7:0];
        CFG_GROW:       grow_r  <= cfg_data[9:0];
        CFG_FSTEP:      fstep_r <= cfg_data[7:0];
        CFG_HIGH_LIM:   high_r  <= cfg_data;
        CFG_LOW_LIM:    low_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_ret_r   <= S_IDLE;
      id_r        <= 64'd0;
      id_len_r    <= 4'd0;
      sc_r        <= 8'd0;
      heard_r     <= 8'd0;
      rate_r      <= RST_RATE;
      period_r    <= RST_PERIOD;
      next_seq_r  <= 16'd0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one is loaded
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            res_kind_r  <= (cmd == CMD_SET_ID && len_bad) ? KIND_REJECT : KIND_DONE;
            res_seq_r   <= 16'd0;
            res_id_r    <= 64'd0;
            res_cnt_r   <= 4'd0;
            res_taken_r <= 1'b0;
            accepts_r   <= in_accepts;
            unique case (cmd)
              CMD_TICK: begin
                state_r <= (id_len_r != 4'd0) ? S_TICK_DECAY : S_DONE;
              end
              CMD_HEARD: begin
                if (heard_r != 8'hFF) begin
                  heard_r <= heard_r + 8'd1;
                end
                state_r <= S_DONE;
              end
              CMD_SEND_DONE: begin
                pending_r <= 1'b0;
                state_r   <= S_DONE;
              end
              CMD_SET_ID: begin
                if (!len_bad) begin
                  id_r     <= id_masked;
                  id_len_r <= in_len;
                  sc_r     <= 8'd0;
                  heard_r  <= 8'd0;
                end
                state_r <= S_DONE;
              end
              CMD_CLEAR_ID: begin
                id_len_r <= 4'd0;
                state_r  <= S_DONE;
              end
              CMD_START: begin
                // 1.0 / min_period
                quo_r     <= {FP_ONE, {FRAC_BITS{1'b0}}};
                rem_r     <= 16'd0;
                den_r     <= min_r;
                cnt_r     <= CNTW'(DIVW);
                div_ret_r <= S_START_DIV2;
                state_r   <= S_DIV;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end

        // Decay the rate, fold in heard messages, count the second
        S_TICK_DECAY: begin
          rate_r  <= rsum_sat;
          heard_r <= 8'd0;
          if (sc_r != 8'hFF) begin
            sc_r <= sc_r + 8'd1;
          end
          state_r <= S_TICK_CHECK;
        end

        S_TICK_CHECK: begin
          work_r  <= period_r;
          state_r <= period_not_due ? S_DONE : S_ADAPT_RATE;
        end

        S_ADAPT_RATE: begin
          adapt_rate_r <= mul_sat;
          state_r      <= S_ADAPT_SEL;
        end

        S_ADAPT_SEL: begin
          priority if (adapt_rate_r > high_r) begin
            state_r <= S_GROW;
          end else if (adapt_rate_r < low_r) begin
            state_r <= S_SHRINK;
          end else begin
            state_r <= S_CLAMP;
          end
        end

        S_GROW: begin
          work_r  <= mul_sat;
          state_r <= S_CLAMP;
        end

        // Period over (1 + step * period)
        S_SHRINK: begin
          quo_r     <= {work_r, {FRAC_BITS{1'b0}}};
          rem_r     <= 16'd0;
          den_r     <= sdiv;
          cnt_r     <= CNTW'(DIVW);
          div_ret_r <= S_SHRINK_FIN;
          state_r   <= S_DIV;
        end

        S_SHRINK_FIN: begin
          work_r  <= div_q_sat;
          state_r <= S_CLAMP;
        end

        // Store the period and issue the broadcast when none is pending
        S_CLAMP: begin
          period_r <= clamped;
          sc_r     <= 8'd0;
          if (!pending_r) begin
            res_kind_r  <= KIND_BCAST;
            res_seq_r   <= next_seq_r;
            res_id_r    <= id_r;
            res_cnt_r   <= id_len_r;
            res_taken_r <= accepts_r;
            next_seq_r  <= next_seq_r + 16'd1;
            if (accepts_r) begin
              pending_r <= 1'b1;
              if (heard_r != 8'hFF) begin
                heard_r <= heard_r + 8'd1;
              end
            end
          end
          state_r <= S_DONE;
        end

        // Previous quotient over the decay complement
        S_START_DIV2: begin
          quo_r     <= {div_q_sat, {FRAC_BITS{1'b0}}};
          rem_r     <= 16'd0;
          den_r     <= decay_comp;
          cnt_r     <= CNTW'(DIVW);
          div_ret_r <= S_START_FIN;
          state_r   <= S_DIV;
        end

        S_START_FIN: begin
          rate_r    <= div_q_sat;
          period_r  <= min_r;
          pending_r <= 1'b0;
          state_r   <= S_DONE;
        end

        // Advance the divider by one quotient bit
        S_DIV: begin
          rem_r <= trial_ge ? diff[15:0] : trial[15:0];
          quo_r <= {quo_r[DIVW-2:0], trial_ge};
          cnt_r <= cnt_r - CNTW'(1);
          if (cnt_r == CNTW'(1)) begin
            state_r <= div_ret_r;
          end
        end

        // Load the output register once it is free
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= res_kind_r;
            out_seq_r    <= res_seq_r;
            out_period_r <= period_r;
            out_rate_r   <= rate_r;
            out_id_r     <= res_id_r;
            out_cnt_r    <= res_cnt_r;
            out_taken_r  <= res_taken_r;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {{PADW{1'b0}}, out_taken_r, out_cnt_r, out_id_r,
                       out_rate_r, out_period_r, out_seq_r};

endmodule

>>> rtl/abp_checker.sv
// ----------------------------------------------------------------------------
// abp_checker
// Port-level checks of the adaptive beacon period block, bound to its top.
// ----------------------------------------------------------------------------
`include "adaptive_beacon_period_assert.svh"

module abp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [abp_pkg::OUT_TUSER_W-1:0] out_tuser,
  input logic [abp_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import abp_pkg::*;

  logic is_bcast;
  logic quiet_ok;
  logic len_ok;
  assign is_bcast = (out_tuser == KIND_BCAST);
  assign quiet_ok = (out_tdata[15:0] == 16'd0) && (out_tdata[111:48] == 64'd0) &&
                    (out_tdata[116:112] == 5'd0);
  assign len_ok   = (out_tdata[115:112] != 4'd0) && (out_tdata[115:112] <= 4'(ID_BYTES));

  // A stalled result stays offered
  `ABP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)

  // The sequencer is busy right after it takes an item
  `ABP_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

  // Only broadcasts carry sequence, identity and send fields
  `ABP_ASSERT_SAME(a_quiet_fields, out_tvalid && !is_bcast, quiet_ok)

  // A broadcast always carries a held identity
  `ABP_ASSERT_SAME(a_bcast_len, out_tvalid && is_bcast, len_ok)

endmodule

bind adaptive_beacon_period abp_checker u_abp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);
